### design/kslp_pkg.sv
// Shared types and constants for the key scanner with long press and repeat.
// Used by every module of the scanner; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kslp_pkg;

   localparam int SINGLE_KEYS = 8;
   localparam int PIN_W       = 8;
   localparam int TICK_W      = 32;
   localparam int TIME_W      = 16;
   localparam int SOURCE_W    = 4;
   localparam int KIND_W      = 2;
   localparam int CMD_W       = 2;
   localparam int PIN_IDX_W   = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Commands carried by an input beat; the fourth code does nothing.
   localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LONG   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

   localparam logic [SOURCE_W-1:0] SOURCE_COMBO = 4'd8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_LONG_TIME   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COMBO_LONG_TIME    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_INTERVAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_MINIMUM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_REPEAT_MASK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COMBO_REPEAT_ON    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COMBO_PIN_FIRST    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COMBO_PIN_SECOND   = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PIN_W-1:0]  pin_levels;
      logic [TICK_W-1:0] tick_now;
   } kslp_req_type;

   typedef struct packed {
      logic                event_valid;
      logic [SOURCE_W-1:0] key_source;
      logic [KIND_W-1:0]   event_kind;
   } kslp_rsp_type;

   // Timing settings common to every key lane.
   typedef struct packed {
      logic [TIME_W-1:0] repeat_interval;
      logic [TIME_W-1:0] release_minimum;
   } kslp_timing_type;

   // What one lane found in the current scan.
   typedef struct packed {
      logic              fire;
      logic [KIND_W-1:0] kind;
   } kslp_hit_type;

   // Per-beat controls from the top level to every lane.
   typedef struct packed {
      logic step_en;
      logic start_en;
   } kslp_lane_ctrl_type;

endpackage

`default_nettype wire

### design/key_scan_long_press_repeat.sv
// Key scanner with short, long and repeat events for eight active-low single
// keys and one combo key. It takes one input beat per clock cycle while
// req_stall is low and gives exactly one result beat per input beat, via the
// output register. Each key has its own lane with a 32-bit subtract and two
// compares, and all nine lanes evaluate in the same cycle, so the longest path
// is the lane compare followed by the merging stage. The output register and
// a skid stage let the next input beat be taken while a result waits;
// req_stall rises only when both are full. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module key_scan_long_press_repeat (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire kslp_pkg::kslp_req_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output kslp_pkg::kslp_rsp_type               rsp_data,
   input  wire logic                            csr_write_enable,
   input  wire logic [kslp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kslp_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import kslp_pkg::*;

   // Configuration registers.
   logic [TIME_W-1:0]      single_long_time_ff;
   logic [TIME_W-1:0]      combo_long_time_ff;
   logic [TIME_W-1:0]      repeat_interval_ff;
   logic [TIME_W-1:0]      release_minimum_ff;
   logic [SINGLE_KEYS-1:0] single_repeat_mask_ff;
   logic                   combo_repeat_on_ff;
   logic [PIN_IDX_W-1:0]   combo_pin_first_ff;
   logic [PIN_IDX_W-1:0]   combo_pin_second_ff;

   logic               accept;
   logic               pend_valid;
   logic               combo_down;
   kslp_lane_ctrl_type lane_ctrl;
   kslp_timing_type    timing;
   kslp_hit_type       combo_hit;
   kslp_hit_type       single_hits [SINGLE_KEYS];
   kslp_rsp_type       result;

   // Output register and skid stage.
   logic         out_valid_ff;
   logic         out_valid_in;
   kslp_rsp_type out_data_ff;
   kslp_rsp_type out_data_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   kslp_rsp_type skid_data_ff;
   kslp_rsp_type skid_data_in;
   logic         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_long_time_ff   <= TIME_W'(500);
         combo_long_time_ff    <= TIME_W'(2000);
         repeat_interval_ff    <= TIME_W'(200);
         release_minimum_ff    <= TIME_W'(100);
         single_repeat_mask_ff <= SINGLE_KEYS'(1);
         combo_repeat_on_ff    <= 1'b0;
         combo_pin_first_ff    <= PIN_IDX_W'(0);
         combo_pin_second_ff   <= PIN_IDX_W'(4);
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SINGLE_LONG_TIME: begin
               single_long_time_ff <= csr_write_data[TIME_W-1:0];
            end
            REG_COMBO_LONG_TIME: begin
               combo_long_time_ff <= csr_write_data[TIME_W-1:0];
            end
            REG_REPEAT_INTERVAL: begin
               repeat_interval_ff <= csr_write_data[TIME_W-1:0];
            end
            REG_RELEASE_MINIMUM: begin
               release_minimum_ff <= csr_write_data[TIME_W-1:0];
            end
            REG_SINGLE_REPEAT_MASK: begin
               single_repeat_mask_ff <= csr_write_data[SINGLE_KEYS-1:0];
            end
            REG_COMBO_REPEAT_ON: begin
               combo_repeat_on_ff <= csr_write_data[0];
            end
            REG_COMBO_PIN_FIRST: begin
               combo_pin_first_ff <= csr_write_data[PIN_IDX_W-1:0];
            end
            REG_COMBO_PIN_SECOND: begin
               combo_pin_second_ff <= csr_write_data[PIN_IDX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   // A scan is skipped altogether while the slot holds an event.
   assign lane_ctrl.step_en  = accept && (req_data.cmd == CMD_SCAN) && !pend_valid;
   assign lane_ctrl.start_en = accept && (req_data.cmd == CMD_START);

   assign timing.repeat_interval = repeat_interval_ff;
   assign timing.release_minimum = release_minimum_ff;

   assign combo_down = !req_data.pin_levels[combo_pin_first_ff] &&
                       !req_data.pin_levels[combo_pin_second_ff];

   kslp_lane u_combo_lane (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .restart   (1'b0),
      .pressed   (combo_down),
      .repeat_on (combo_repeat_on_ff),
      .long_time (combo_long_time_ff),
      .timing    (timing),
      .tick_now  (req_data.tick_now),
      .hit       (combo_hit)
   );

   for (genvar g = 0; g < SINGLE_KEYS; g++) begin : g_single
      kslp_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .restart   (combo_down),
         .pressed   (!req_data.pin_levels[g]),
         .repeat_on (single_repeat_mask_ff[g]),
         .long_time (single_long_time_ff),
         .timing    (timing),
         .tick_now  (req_data.tick_now),
         .hit       (single_hits[g])
      );
   end

   kslp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_data.cmd),
      .combo_hit   (combo_hit),
      .single_hits (single_hits),
      .pend_valid  (pend_valid),
      .result      (result)
   );

   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            // The output beat is stalled, so the new result waits in the skid stage.
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

### design/kslp_lane.sv
// One key lane: timer, lock bit and the press/release decision for a single key.
// Depends on kslp_pkg; instantiated once per single key and once for the combo key.
`timescale 1ns / 1ps
`default_nettype none

module kslp_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire kslp_pkg::kslp_lane_ctrl_type ctrl,
   input  wire logic                        restart,
   input  wire logic                        pressed,
   input  wire logic                        repeat_on,
   input  wire logic [kslp_pkg::TIME_W-1:0] long_time,
   input  wire kslp_pkg::kslp_timing_type   timing,
   input  wire logic [kslp_pkg::TICK_W-1:0] tick_now,
   output kslp_pkg::kslp_hit_type           hit
);
   import kslp_pkg::*;

   logic [TICK_W-1:0] timer_ff;
   logic [TICK_W-1:0] timer_in;
   logic              locked_ff;
   logic              locked_in;
   logic [TICK_W-1:0] elapsed;
   logic [TIME_W-1:0] limit;
   logic              over_limit;
   logic              over_release;

   // A combo press restarts the timer before the key is judged, so the
   // elapsed time is then zero and nothing can qualify.
   assign elapsed = restart ? '0 : (tick_now - timer_ff);
   assign limit   = locked_ff ? timing.repeat_interval : long_time;

   assign over_limit   = (|elapsed[TICK_W-1:TIME_W]) || (elapsed[TIME_W-1:0] > limit);
   assign over_release = (|elapsed[TICK_W-1:TIME_W]) ||
                         (elapsed[TIME_W-1:0] > timing.release_minimum);

   always_comb begin
      timer_in  = timer_ff;
      locked_in = locked_ff;
      hit       = '0;
      if (ctrl.step_en) begin
         if (restart) begin
            timer_in = tick_now;
         end
         if (pressed) begin
            if (!locked_ff || repeat_on) begin
               if (over_limit) begin
                  hit.fire  = 1'b1;
                  hit.kind  = locked_ff ? KIND_REPEAT : KIND_LONG;
                  locked_in = 1'b1;
                  timer_in  = tick_now;
               end
            end else begin
               // Locked without repeat: the timer just follows the tick.
               timer_in = tick_now;
            end
         end else begin
            if (over_release) begin
               hit.fire = 1'b1;
               hit.kind = KIND_SHORT;
            end
            locked_in = 1'b0;
            timer_in  = tick_now;
         end
      end else if (ctrl.start_en) begin
         timer_in = tick_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff  <= '0;
         locked_ff <= 1'b0;
      end else begin
         timer_ff  <= timer_in;
         locked_ff <= locked_in;
      end
   end

endmodule

`default_nettype wire

### design/kslp_merge.sv
// Merging stage: picks the last qualifying lane, holds the pending event slot
// and forms the result of each beat. Depends on kslp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kslp_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [kslp_pkg::CMD_W-1:0] cmd,
   input  wire kslp_pkg::kslp_hit_type     combo_hit,
   input  wire kslp_pkg::kslp_hit_type     single_hits [kslp_pkg::SINGLE_KEYS],
   output logic                            pend_valid,
   output kslp_pkg::kslp_rsp_type          result
);
   import kslp_pkg::*;

   kslp_rsp_type slot_ff;
   kslp_rsp_type slot_in;
   kslp_rsp_type winner;

   // Combo first, then single keys in ascending order; the last one wins.
   always_comb begin
      winner = '0;
      if (combo_hit.fire) begin
         winner.event_valid = 1'b1;
         winner.key_source  = SOURCE_COMBO;
         winner.event_kind  = combo_hit.kind;
      end
      for (int i = 0; i < SINGLE_KEYS; i++) begin
         if (single_hits[i].fire) begin
            winner.event_valid = 1'b1;
            winner.key_source  = SOURCE_W'(i);
            winner.event_kind  = single_hits[i].kind;
         end
      end
   end

   // Lanes only fire on a scan with an empty slot, so the winner is the slot
   // after the beat; otherwise the beat reports the slot as it stands.
   assign result     = winner.event_valid ? winner : slot_ff;
   assign pend_valid = slot_ff.event_valid;

   always_comb begin
      slot_in = slot_ff;
      if (accept) begin
         if (cmd == CMD_TAKE) begin
            slot_in = '0;
         end else if (winner.event_valid) begin
            slot_in = winner;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire
